@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the hash table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is active
`define AST_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is active
`define AST_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define AST_IMP(name, clk, rst_n, ante, cons)
`define AST_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/emht_pkg.sv @@
// ----------------------------------------------------------------------------
// emht_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package emht_pkg;

	localparam int BUCKET_COUNT_DEF = 128;
	localparam int POOL_SLOTS_DEF   = 256;

	localparam logic       ACTION_INSERT = 1'b0;
	localparam logic       ACTION_LOOKUP = 1'b1;

	localparam logic [1:0] RES_OK   = 2'd0;
	localparam logic [1:0] RES_MISS = 2'd1;
	localparam logic [1:0] RES_FULL = 2'd2;

	typedef struct packed {
		logic       clr;
		logic       capture;
		logic       mul;
		logic       hash_start;
		logic       hash_step;
		logic       slot_rd;
		logic       from_head;
		logic       upd;
		logic       alloc;
		logic       finish;
		logic       found;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hash_done;
		logic head_null;
		logic next_null;
		logic hit;
		logic is_lookup;
		logic pool_full;
	} stat_t;

endpackage

`default_nettype wire

@@ rtl/emht_ctrl.sv @@
// ----------------------------------------------------------------------------
// emht_ctrl
// Sequencer: clears bucket heads after reset, then runs hash, chain walk and
// slot update or allocation for each request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module emht_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire emht_pkg::stat_t st,
	output emht_pkg::cmd_t      cmd
);
	import emht_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_MUL   = 8'b0000_0100,
		S_HASH  = 8'b0000_1000,
		S_HEAD  = 8'b0001_0000,
		S_LINK  = 8'b0010_0000,
		S_SLOT  = 8'b0100_0000,
		S_ALLOC = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul        = 1'b1;
				cmd.hash_start = 1'b1;
				state_d        = S_HASH;
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (st.hash_done) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				state_d = S_LINK;
			end
			S_LINK: begin
				if (!st.head_null) begin
					cmd.slot_rd   = 1'b1;
					cmd.from_head = 1'b1;
					state_d       = S_SLOT;
				end else if (st.is_lookup) begin
					cmd.finish = 1'b1;
					cmd.code   = RES_MISS;
					state_d    = S_IDLE;
				end else begin
					state_d = S_ALLOC;
				end
			end
			S_SLOT: begin
				// lookup: valid match; insert: first invalid slot
				if (st.hit) begin
					cmd.upd    = 1'b1;
					cmd.finish = 1'b1;
					cmd.code   = RES_OK;
					cmd.found  = st.is_lookup;
					state_d    = S_IDLE;
				end else if (!st.next_null) begin
					cmd.slot_rd = 1'b1;
				end else if (st.is_lookup) begin
					cmd.finish = 1'b1;
					cmd.code   = RES_MISS;
					state_d    = S_IDLE;
				end else begin
					state_d = S_ALLOC;
				end
			end
			S_ALLOC: begin
				cmd.finish = 1'b1;
				if (st.pool_full) begin
					cmd.code = RES_FULL;
				end else begin
					cmd.alloc = 1'b1;
					cmd.code  = RES_OK;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`AST_NXT(a_finish_idle, clk, arst_n, cmd.finish, state_q == S_IDLE)
	`AST_IMP(a_alloc_room, clk, arst_n, cmd.alloc, !st.pool_full)
	`AST_NXT(a_read_walks, clk, arst_n, cmd.slot_rd, state_q == S_SLOT)

endmodule

`default_nettype wire

@@ rtl/emht_datapath.sv @@
// ----------------------------------------------------------------------------
// emht_datapath
// Key ordering, bucket hash, bucket head memory, slot pool memory and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module emht_datapath #(
	parameter int BUCKET_COUNT = emht_pkg::BUCKET_COUNT_DEF,
	parameter int POOL_SLOTS   = emht_pkg::POOL_SLOTS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire emht_pkg::cmd_t cmd,
	output emht_pkg::stat_t     st,
	input  wire logic           action,
	input  wire logic [15:0]    vertex_a,
	input  wire logic [15:0]    vertex_b,
	input  wire logic [15:0]    midpoint_in,
	output logic                done,
	output logic [1:0]          status,
	output logic [15:0]         midpoint_out
);
	import emht_pkg::*;

	localparam int BW = $clog2(BUCKET_COUNT);
	localparam int SW = $clog2(POOL_SLOTS);
	localparam int LW = SW + 1;
	localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SLOTS);
	localparam bit BKT_POW2 = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);

	typedef struct packed {
		logic          valid;
		logic [15:0]   lo;
		logic [15:0]   hi;
		logic [15:0]   mid;
		logic [LW-1:0] next;
	} slot_t;

	logic          action_q;
	logic [15:0]   lo_q;
	logic [15:0]   hi_q;
	logic [15:0]   mid_q;
	logic [31:0]   prod_q;
	logic [BW-1:0] bucket;
	logic          hash_done;

	logic [LW-1:0] head_mem [BUCKET_COUNT];
	logic [LW-1:0] head_q;
	logic [BW-1:0] clr_idx_q;

	slot_t         slot_mem [POOL_SLOTS];
	slot_t         slot_rd_q;
	slot_t         slot_wdata;
	logic [SW-1:0] slot_raddr;
	logic [SW-1:0] slot_waddr;
	logic          slot_we;
	logic [SW-1:0] cur_q;
	logic [LW-1:0] pool_cnt_q;

	logic          done_q;
	logic [1:0]    status_q;
	logic [15:0]   mid_out_q;

	// order the key, then form the product
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			mid_q    <= midpoint_in;
			if (vertex_a < vertex_b) begin
				lo_q <= vertex_a;
				hi_q <= vertex_b;
			end else begin
				lo_q <= vertex_b;
				hi_q <= vertex_a;
			end
		end
		if (cmd.mul) begin
			prod_q <= 32'(lo_q) * 32'(hi_q);
		end
	end

	if (BKT_POW2) begin : g_hash_pow2
		assign bucket    = prod_q[BW-1:0];
		assign hash_done = 1'b1;
	end else begin : g_hash_fold
		localparam int FW  = 16 + BW;
		localparam int RSH = FW + BW;
		localparam int PW  = 2 * FW + 1;
		localparam longint unsigned FOLD_K_L = (64'd1 << 16) % BUCKET_COUNT;
		localparam longint unsigned RECIP_L  =
			((64'd1 << RSH) + BUCKET_COUNT - 1) / BUCKET_COUNT;
		localparam logic [BW-1:0] FOLD_K = BW'(FOLD_K_L);
		localparam logic [FW:0]   RECIP  = (FW + 1)'(RECIP_L);

		logic [FW-1:0] fold_q;
		logic [15:0]   quot_q;
		logic [BW-1:0] rem_q;
		logic [PW-1:0] recip_prod;
		logic [1:0]    phase_q;

		// fold the upper product half by 2^16 mod N, then reduce with a reciprocal
		assign recip_prod = PW'(fold_q) * PW'(RECIP);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				phase_q <= '0;
			end else if (cmd.hash_start) begin
				phase_q <= '0;
			end else if (cmd.hash_step) begin
				phase_q <= phase_q + 2'd1;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.hash_step) begin
				if (phase_q == 2'd0) begin
					fold_q <= FW'(prod_q[31:16]) * FW'(FOLD_K) + FW'(prod_q[15:0]);
				end
				if (phase_q == 2'd1) begin
					quot_q <= recip_prod[RSH +: 16];
				end
				if (phase_q == 2'd2) begin
					rem_q <= BW'(fold_q - FW'(quot_q) * FW'(BUCKET_COUNT));
				end
			end
		end

		assign bucket    = rem_q;
		assign hash_done = (phase_q == 2'd2);
	end

	// bucket heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			head_mem[clr_idx_q] <= NULL_LINK;
		end else if (cmd.alloc) begin
			head_mem[bucket] <= pool_cnt_q;
		end
		head_q <= head_mem[bucket];
	end

	// slot pool: one read and one write port
	assign slot_raddr = cmd.from_head ? head_q[SW-1:0] : slot_rd_q.next[SW-1:0];
	assign slot_we    = cmd.upd || cmd.alloc;
	assign slot_waddr = cmd.alloc ? pool_cnt_q[SW-1:0] : cur_q;

	always_comb begin
		if (cmd.alloc) begin
			slot_wdata = '{valid: 1'b1, lo: lo_q, hi: hi_q, mid: mid_q, next: head_q};
		end else if (action_q == ACTION_LOOKUP) begin
			slot_wdata       = slot_rd_q;
			slot_wdata.valid = 1'b0;
		end else begin
			slot_wdata = '{valid: 1'b1, lo: lo_q, hi: hi_q, mid: mid_q,
				next: slot_rd_q.next};
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		slot_rd_q <= slot_mem[slot_raddr];
		if (cmd.slot_rd) begin
			cur_q <= slot_raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_cnt_q <= '0;
		end else if (cmd.alloc) begin
			pool_cnt_q <= pool_cnt_q + 1'b1;
		end
	end

	// status toward the sequencer
	always_comb begin
		st.clr_last  = (clr_idx_q == BW'(BUCKET_COUNT - 1));
		st.hash_done = hash_done;
		st.head_null = (head_q == NULL_LINK);
		st.next_null = (slot_rd_q.next == NULL_LINK);
		st.is_lookup = (action_q == ACTION_LOOKUP);
		st.hit       = (action_q == ACTION_LOOKUP)
			? (slot_rd_q.valid && (slot_rd_q.lo == lo_q) && (slot_rd_q.hi == hi_q))
			: !slot_rd_q.valid;
		st.pool_full = (pool_cnt_q == NULL_LINK);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q  <= cmd.code;
			mid_out_q <= cmd.found ? slot_rd_q.mid : 16'd0;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign midpoint_out = mid_out_q;

	`AST_NXT(a_done_pulse, clk, arst_n, done_q, !done_q)
	`AST_NXT(a_pool_step, clk, arst_n, cmd.alloc, pool_cnt_q == $past(pool_cnt_q) + LW'(1))
	`AST_IMP(a_upd_in_pool, clk, arst_n, cmd.upd, LW'(cur_q) < pool_cnt_q)

endmodule

`default_nettype wire

@@ rtl/edge_midpoint_hash_table.sv @@
// Sequence: a request passes the multiply, hash, head and link states, then reads
// chain slots; an insert with no free slot ends in the allocate step. A bucket
// count that is not a power of two takes fold, quotient and remainder hash steps.
// One request at a time: busy drops in the cycle done is high.
// Reset: every bucket head is cleared in turn with busy high.
// The receiver cannot stall; status and midpoint_out are valid while done.
// ----------------------------------------------------------------------------
// edge_midpoint_hash_table
// Chained hash table caching mesh edge midpoints: insert and lookup-delete.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_midpoint_hash_table #(
	parameter int BUCKET_COUNT = emht_pkg::BUCKET_COUNT_DEF,
	parameter int POOL_SLOTS   = emht_pkg::POOL_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [15:0] vertex_a,
	input  wire logic [15:0] vertex_b,
	input  wire logic [15:0] midpoint_in,
	output logic             done,
	output logic [1:0]       status,
	output logic [15:0]      midpoint_out
);
	import emht_pkg::*;

	cmd_t  cmd;
	stat_t st;

	emht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	emht_datapath #(
		.BUCKET_COUNT (BUCKET_COUNT),
		.POOL_SLOTS   (POOL_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.action       (action),
		.vertex_a     (vertex_a),
		.vertex_b     (vertex_b),
		.midpoint_in  (midpoint_in),
		.done         (done),
		.status       (status),
		.midpoint_out (midpoint_out)
	);

endmodule

`default_nettype wire
